// ===== design/cmrc_pkg.sv =====
package cmrc_pkg;

   localparam int unsigned GRID_SIDE_DEFAULT = 2;

   typedef struct packed {
      logic [7:0] sample_red;
      logic [7:0] sample_green;
      logic [7:0] sample_blue;
      logic       sample_covered;
      logic [7:0] cell_glyph;
      logic       last_sample;
      logic       row_end;
      logic       frame_end;
   } req_word_type;

   typedef struct packed {
      logic [7:0] glyph_out;
      logic       set_color;
      logic [7:0] color_red;
      logic [7:0] color_green;
      logic [7:0] color_blue;
      logic       reset_color;
      logic       newline_after;
      logic       final_reset;
      logic       frame_done;
   } rsp_word_type;

endpackage

// ===== design/cmrc_stream_if.sv =====
interface cmrc_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== design/cell_msaa_resolve_color_runs_unit.sv =====
// Box-filter resolve of a supersampled character frame with color-run flags.
// Path: a sample word is captured in the input register at acceptance; a
//   cell's last sample word yields a result word in the output register.
// Throughput: one sample word per clock while the output register is free or
//   taken by rsp; the sum and color-state update loop is combinational.
// Reset (synchronous, active high): sums, coverage and active color clear.
module cell_msaa_resolve_color_runs_unit #(
   parameter int unsigned GRID_SIDE = cmrc_pkg::GRID_SIDE_DEFAULT
) (
   input logic            clock,
   input logic            reset,
   cmrc_stream_if.sink    req_if,
   cmrc_stream_if.source  rsp_if
);

   localparam int unsigned SAMPLES = GRID_SIDE * GRID_SIDE;
   localparam int unsigned SUM_MAX = 255 * SAMPLES;
   localparam int unsigned SUM_W   = $clog2(SUM_MAX + 1);
   localparam int unsigned RND_W   = SUM_W + 1;
   localparam int unsigned SHIFT   = RND_W + $clog2(SAMPLES);
   localparam int unsigned RECIP   = ((32'd1 << SHIFT) + SAMPLES - 1) / SAMPLES;
   localparam int unsigned PROD_W  = RND_W + SHIFT + 1;

   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                                input logic [7:0] v);
      logic [SUM_W:0] s;
      s = {1'b0, acc} + (SUM_W + 1)'(v);
      if (s > (SUM_W + 1)'(SUM_MAX)) begin
         return SUM_W'(SUM_MAX);
      end
      return s[SUM_W-1:0];
   endfunction

   // rounded divide by the sample count through a reciprocal multiply
   function automatic logic [7:0] resolve(input logic [SUM_W-1:0] sum);
      logic [RND_W-1:0]  rnd;
      logic [PROD_W-1:0] prod;
      rnd  = RND_W'(sum) + RND_W'(SAMPLES / 2);
      prod = PROD_W'(rnd) * PROD_W'(RECIP);
      return prod[SHIFT +: 8];
   endfunction

   logic                  in_valid_ff;
   cmrc_pkg::req_word_type in_word_ff;
   logic                  out_valid_ff;
   cmrc_pkg::rsp_word_type out_word_ff;

   logic [SUM_W-1:0] sum_red_ff, sum_green_ff, sum_blue_ff;
   logic [SUM_W-1:0] sum_red_in, sum_green_in, sum_blue_in;
   logic             any_covered_ff, any_covered_in;
   logic             fg_on_ff, fg_on_in;
   logic [7:0]       active_red_ff, active_green_ff, active_blue_ff;
   logic [7:0]       active_red_in, active_green_in, active_blue_in;

   logic             out_free;
   logic             move;
   logic             emit;
   logic [SUM_W-1:0] acc_red, acc_green, acc_blue;
   logic             acc_any;
   logic [7:0]       res_red, res_green, res_blue;
   logic             do_set, do_reset, active_after;
   cmrc_pkg::rsp_word_type rsp_word;

   assign out_free     = !out_valid_ff || rsp_if.ready;
   assign move         = in_valid_ff && (!in_word_ff.last_sample || out_free);
   assign emit         = move && in_word_ff.last_sample;
   assign req_if.ready = !in_valid_ff || move;

   always_comb begin
      if (in_word_ff.sample_covered) begin
         acc_red   = sat_add(sum_red_ff, in_word_ff.sample_red);
         acc_green = sat_add(sum_green_ff, in_word_ff.sample_green);
         acc_blue  = sat_add(sum_blue_ff, in_word_ff.sample_blue);
      end else begin
         acc_red   = sum_red_ff;
         acc_green = sum_green_ff;
         acc_blue  = sum_blue_ff;
      end
      acc_any   = any_covered_ff || in_word_ff.sample_covered;
      res_red   = resolve(acc_red);
      res_green = resolve(acc_green);
      res_blue  = resolve(acc_blue);

      do_set   = acc_any && (!fg_on_ff || res_red != active_red_ff
                             || res_green != active_green_ff
                             || res_blue != active_blue_ff);
      do_reset = !acc_any && fg_on_ff;
      active_after = do_set || (fg_on_ff && !do_reset);

      rsp_word.glyph_out     = in_word_ff.cell_glyph;
      rsp_word.set_color     = do_set;
      rsp_word.color_red     = res_red;
      rsp_word.color_green   = res_green;
      rsp_word.color_blue    = res_blue;
      rsp_word.reset_color   = do_reset;
      rsp_word.newline_after = in_word_ff.row_end && !in_word_ff.frame_end;
      rsp_word.final_reset   = in_word_ff.frame_end && active_after;
      rsp_word.frame_done    = in_word_ff.frame_end;
   end

   always_comb begin
      sum_red_in      = sum_red_ff;
      sum_green_in    = sum_green_ff;
      sum_blue_in     = sum_blue_ff;
      any_covered_in  = any_covered_ff;
      fg_on_in        = fg_on_ff;
      active_red_in   = active_red_ff;
      active_green_in = active_green_ff;
      active_blue_in  = active_blue_ff;
      if (move) begin
         if (in_word_ff.last_sample) begin
            sum_red_in     = '0;
            sum_green_in   = '0;
            sum_blue_in    = '0;
            any_covered_in = 1'b0;
            if (in_word_ff.frame_end) begin
               fg_on_in        = 1'b0;
               active_red_in   = '0;
               active_green_in = '0;
               active_blue_in  = '0;
            end else if (do_set) begin
               fg_on_in        = 1'b1;
               active_red_in   = res_red;
               active_green_in = res_green;
               active_blue_in  = res_blue;
            end else if (do_reset) begin
               fg_on_in = 1'b0;
            end
         end else begin
            sum_red_in     = acc_red;
            sum_green_in   = acc_green;
            sum_blue_in    = acc_blue;
            any_covered_in = acc_any;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         sum_red_ff      <= '0;
         sum_green_ff    <= '0;
         sum_blue_ff     <= '0;
         any_covered_ff  <= 1'b0;
         fg_on_ff        <= 1'b0;
         active_red_ff   <= '0;
         active_green_ff <= '0;
         active_blue_ff  <= '0;
      end else begin
         if (req_if.ready) begin
            in_valid_ff <= req_if.valid;
         end
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            out_valid_ff <= 1'b0;
         end
         sum_red_ff      <= sum_red_in;
         sum_green_ff    <= sum_green_in;
         sum_blue_ff     <= sum_blue_in;
         any_covered_ff  <= any_covered_in;
         fg_on_ff        <= fg_on_in;
         active_red_ff   <= active_red_in;
         active_green_ff <= active_green_in;
         active_blue_ff  <= active_blue_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         in_word_ff <= req_if.payload;
      end
      if (emit) begin
         out_word_ff <= rsp_word;
      end
   end

   assign rsp_if.valid   = out_valid_ff;
   assign rsp_if.payload = out_word_ff;

   a_set_reset_exclusive: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_word_ff.set_color && out_word_ff.reset_color))
      else $error("set and reset of color in one word");

   a_reset_black: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_word_ff.reset_color) |->
         (out_word_ff.color_red == 8'd0 && out_word_ff.color_green == 8'd0
          && out_word_ff.color_blue == 8'd0))
      else $error("uncovered cell resolved to a nonzero color");

   a_final_in_frame: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (!out_word_ff.final_reset || out_word_ff.frame_done)
                       && !(out_word_ff.newline_after && out_word_ff.frame_done))
      else $error("frame flags inconsistent");

   a_frame_clears: assert property (@(posedge clock) disable iff (reset)
      (emit && in_word_ff.frame_end) |=> (!fg_on_ff && !any_covered_ff))
      else $error("color state not cleared after frame end");

endmodule
